// File: hdl/sorted_key_table_insert_locate_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Wrappers for the concurrent checks of the sorted key table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_INSERT_LOCATE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_INSERT_LOCATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SKT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define SKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared constants, codes and types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int REF_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2
    } skt_status_t;

    typedef enum logic [1:0] {
        SKT_IDLE,
        SKT_CMP,
        SKT_ENC
    } skt_state_t;

    typedef struct packed {
        logic                    write;
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic [REF_W-1:0]        rec;
    } skt_ctrl_t;

    typedef struct packed {
        logic                    mark;
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [REF_W-1:0]        rec;
    } skt_link_t;

endpackage

// File: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry, compares it with the current key and shifts on insert.
// ----------------------------------------------------------------------------
module skt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  skt_pkg::skt_ctrl_t  ctrl,
    input  skt_pkg::skt_link_t  left,
    output skt_pkg::skt_link_t  link,
    output logic                boundary,
    output logic                equal
);

    logic                            valid_reg;
    logic                            valid_next;
    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic signed [skt_pkg::KEY_W-1:0] key_next;
    logic [skt_pkg::REF_W-1:0]       rec_reg;
    logic [skt_pkg::REF_W-1:0]       rec_next;
    logic                            mark;

    always_comb begin
        if (ctrl.cmd == skt_pkg::CMD_LOCATE) begin
            mark = !valid_reg || (key_reg >= ctrl.key);
        end else begin
            mark = !valid_reg || (key_reg > ctrl.key);
        end
    end

    assign boundary   = mark && !left.mark;
    assign equal      = valid_reg && (key_reg == ctrl.key);
    assign link.mark  = mark;
    assign link.valid = valid_reg;
    assign link.key   = key_reg;
    assign link.rec   = rec_reg;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        rec_next   = rec_reg;
        if (ctrl.write && mark) begin
            if (left.mark) begin
                valid_next = left.valid;
                key_next   = left.key;
                rec_next   = left.rec;
            end else begin
                valid_next = 1'b1;
                key_next   = ctrl.key;
                rec_next   = ctrl.rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
        rec_reg <= rec_next;
    end

endmodule

// File: hdl/skt_encoder.sv
// ----------------------------------------------------------------------------
// Sorted key table position encoder
// Turns the one-hot boundary vector of the cell row into an index.
// ----------------------------------------------------------------------------
module skt_encoder #(
    parameter int N = skt_pkg::CAPACITY_DEF + 1,
    parameter int W = $clog2(skt_pkg::CAPACITY_DEF + 1)
) (
    input  logic [N-1:0] onehot,
    output logic [W-1:0] index
);

    always_comb begin
        index = '0;
        for (int i = 0; i < N; i++) begin
            if (onehot[i]) begin
                index = index | W'(i);
            end
        end
    end

endmodule

// File: hdl/sorted_key_table_insert_locate_unit.sv
// ----------------------------------------------------------------------------
// Sorted key table with insert and locate
// Row of cells holding signed keys in ascending order with record references.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready) carries one command per beat: insert
// puts the pair after every equal key, locate searches for the key. The
// result channel (m_valid, m_ready) returns one beat per command with the
// status, the position and the entry count after the command.
// A result beat is valid once its command has passed the compare and the
// encode state: in the compare state every cell compares its key and the
// row shifts on insert, and in the encode state the boundary position is
// encoded into the output register. No new command is taken until the
// last one leaves the encode state, as the input is closed in both states.
// A result waits in the output register while the receiver stalls; the next
// command is still captured and compared, and its result is held back in the
// encode step until the output register is free.
// Reset empties the table at once by clearing the fill count and every
// cell's valid bit; no clearing pass is needed. No beat is taken in reset.
// ----------------------------------------------------------------------------
`include "sorted_key_table_insert_locate_unit_macros.svh"

module sorted_key_table_insert_locate_unit #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic signed [skt_pkg::KEY_W-1:0]    s_key,
    input  logic [skt_pkg::REF_W-1:0]           s_record_ref,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [skt_pkg::STATUS_W-1:0]        m_status,
    output logic [skt_pkg::POS_W-1:0]           m_position,
    output logic [skt_pkg::POS_W-1:0]           m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    skt_pkg::skt_state_t              state_reg;
    skt_pkg::skt_state_t              state_next;
    logic                             cmd_reg;
    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic [skt_pkg::REF_W-1:0]        rec_reg;
    logic [CNT_W-1:0]                 fill_count_reg;
    logic [CNT_W-1:0]                 fill_count_next;
    logic [CAPACITY:0]                bnd_reg;
    logic                             hit_reg;
    logic                             full_reg;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic [skt_pkg::STATUS_W-1:0]     m_status_reg;
    logic [skt_pkg::POS_W-1:0]        m_position_reg;
    logic [skt_pkg::POS_W-1:0]        m_entry_count_reg;

    logic                             accept;
    logic                             cell_write;
    logic                             load_out;
    logic                             full;
    skt_pkg::skt_ctrl_t               ctrl;
    skt_pkg::skt_link_t               left  [CAPACITY];
    skt_pkg::skt_link_t               link  [CAPACITY];
    logic [CAPACITY:0]                bnd;
    logic [CAPACITY-1:0]              eq;
    logic [CNT_W-1:0]                 pos;
    skt_pkg::skt_status_t             status;

    assign full   = (fill_count_reg == CNT_W'(CAPACITY));
    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::SKT_IDLE: begin
                if (s_valid) begin
                    state_next = skt_pkg::SKT_CMP;
                end
            end
            skt_pkg::SKT_CMP: begin
                state_next = skt_pkg::SKT_ENC;
            end
            skt_pkg::SKT_ENC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = skt_pkg::SKT_IDLE;
                end
            end
            default: begin
                state_next = skt_pkg::SKT_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cell_write = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            skt_pkg::SKT_IDLE: begin
                s_ready = aresetn;
            end
            skt_pkg::SKT_CMP: begin
                cell_write = (cmd_reg == skt_pkg::CMD_INSERT) && !full;
            end
            skt_pkg::SKT_ENC: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign ctrl.write = cell_write;
    assign ctrl.cmd   = cmd_reg;
    assign ctrl.key   = key_reg;
    assign ctrl.rec   = rec_reg;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left[g] = '0;
        end else begin : g_rest
            assign left[g] = link[g-1];
        end
        skt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .left     (left[g]),
            .link     (link[g]),
            .boundary (bnd[g]),
            .equal    (eq[g])
        );
    end

    assign bnd[CAPACITY] = !link[CAPACITY-1].mark;

    skt_encoder #(
        .N (CAPACITY + 1),
        .W (CNT_W)
    ) u_encoder (
        .onehot (bnd_reg),
        .index  (pos)
    );

    always_comb begin
        if (cmd_reg == skt_pkg::CMD_INSERT) begin
            status = full_reg ? skt_pkg::STATUS_FULL : skt_pkg::STATUS_OK;
        end else begin
            status = hit_reg ? skt_pkg::STATUS_OK : skt_pkg::STATUS_MISSING;
        end
    end

    assign fill_count_next = cell_write ? fill_count_reg + CNT_W'(1) : fill_count_reg;
    assign m_valid_next    = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= skt_pkg::SKT_IDLE;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_cmd;
            key_reg <= s_key;
            rec_reg <= s_record_ref;
        end
        if (state_reg == skt_pkg::SKT_CMP) begin
            bnd_reg  <= bnd;
            hit_reg  <= |(bnd[CAPACITY-1:0] & eq);
            full_reg <= full;
        end
        if (load_out) begin
            m_status_reg      <= status;
            m_position_reg    <= (status == skt_pkg::STATUS_FULL) ? '0
                                 : skt_pkg::POS_W'(pos);
            m_entry_count_reg <= skt_pkg::POS_W'(fill_count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_entry_count_reg;

    `SKT_ASSERT_SAME(a_bnd_onehot, aclk, aresetn, state_reg == skt_pkg::SKT_ENC,
        $onehot(bnd_reg), "boundary vector is not one-hot")
    `SKT_ASSERT_NEXT(a_fill_step, aclk, aresetn, cell_write,
        fill_count_reg == $past(fill_count_reg) + CNT_W'(1),
        "fill count did not step on insert")
    `SKT_ASSERT_SAME(a_full_count, aclk, aresetn,
        m_valid_reg && (m_status_reg == skt_pkg::STATUS_FULL),
        m_entry_count_reg == skt_pkg::POS_W'(CAPACITY),
        "full status with a table that is not full")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table insert and locate regression
// Drives insert and locate commands through the valid/ready input channel,
// mirrors the sorted table in a scoreboard and checks the status, position
// and entry count of every result beat, in order, under varying idle and
// stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_BEATS  = 345;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct {
        skt_pkg::skt_status_t      status;
        logic [skt_pkg::POS_W-1:0] position;
        logic [skt_pkg::POS_W-1:0] entry_count;
    } table_result_t;

    class sorted_table_tracker;
        logic signed [skt_pkg::KEY_W-1:0] keys [0:skt_pkg::CAPACITY_DEF-1];
        int unsigned                      held;
        table_result_t                    pending [$];
        int unsigned                      mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic cmd, logic signed [skt_pkg::KEY_W-1:0] key);
            table_result_t r;
            int unsigned   slot;
            int unsigned   idx;
            slot = 0;
            if (cmd == skt_pkg::CMD_INSERT) begin
                if (held >= skt_pkg::CAPACITY_DEF) begin
                    r.status = skt_pkg::STATUS_FULL;
                end else begin
                    while (slot < held && keys[slot] <= key) slot++;
                    for (idx = held; idx > slot; idx--) keys[idx] = keys[idx - 1];
                    keys[slot] = key;
                    held++;
                    r.status = skt_pkg::STATUS_OK;
                end
            end else begin
                while (slot < held && keys[slot] < key) slot++;
                if (slot < held && keys[slot] == key) begin
                    r.status = skt_pkg::STATUS_OK;
                end else begin
                    r.status = skt_pkg::STATUS_MISSING;
                end
            end
            r.position = skt_pkg::POS_W'(slot);
            r.entry_count = skt_pkg::POS_W'(held);
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_response(logic [skt_pkg::STATUS_W-1:0] status,
                            logic [skt_pkg::POS_W-1:0] position,
                            logic [skt_pkg::POS_W-1:0] entry_count);
            table_result_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                          status));
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %s", status,
                                          want.status.name()));
            end
            if (position !== want.position) begin
                report_mismatch($sformatf("position %0d, expected %0d", position,
                                          want.position));
            end
            if (entry_count !== want.entry_count) begin
                report_mismatch($sformatf("entry count %0d, expected %0d", entry_count,
                                          want.entry_count));
            end
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_cmd;
    logic signed [skt_pkg::KEY_W-1:0] s_key;
    logic [skt_pkg::REF_W-1:0]        s_record_ref;
    logic                             m_valid;
    logic                             m_ready;
    logic [skt_pkg::STATUS_W-1:0]     m_status;
    logic [skt_pkg::POS_W-1:0]        m_position;
    logic [skt_pkg::POS_W-1:0]        m_entry_count;

    sorted_table_tracker              tracker;
    int unsigned                      src_idle_pct;
    int unsigned                      sink_idle_pct;
    int unsigned                      cycle_count = 0;
    logic signed [skt_pkg::KEY_W-1:0] boundary_keys [0:5];

    sorted_key_table_insert_locate_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_record_ref  (s_record_ref),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_entry_count (m_entry_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_key_table_insert_locate_unit regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_response(m_status, m_position, m_entry_count);
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = aresetn && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_command(logic cmd, logic signed [skt_pkg::KEY_W-1:0] key,
                                logic [skt_pkg::REF_W-1:0] rec);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = cmd;
        s_key = key;
        s_record_ref = rec;
        do @(posedge aclk); while (!s_ready);
        tracker.note_command(cmd, key);
        @(negedge aclk);
    endtask

    function automatic logic signed [skt_pkg::KEY_W-1:0] pick_insert_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return int'($urandom_range(16)) - 8;
        if (roll < 55) return boundary_keys[$urandom_range(5)];
        return $urandom;
    endfunction

    function automatic logic signed [skt_pkg::KEY_W-1:0] pick_locate_key();
        int unsigned                      roll;
        logic signed [skt_pkg::KEY_W-1:0] base;
        roll = $urandom_range(99);
        if (tracker.held == 0 || roll >= 80) return $urandom;
        base = tracker.keys[$urandom_range(tracker.held - 1)];
        if (roll < 45) return base;
        if (roll < 65) return $urandom_range(1) ? base + 1 : base - 1;
        return boundary_keys[$urandom_range(5)];
    endfunction

    function automatic logic [skt_pkg::REF_W-1:0] pick_record_ref();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return $urandom;
    endfunction

    initial begin
        int unsigned phase;
        int unsigned n;
        tracker = new();
        boundary_keys[0] = 32'h8000_0000;
        boundary_keys[1] = 32'h8000_0001;
        boundary_keys[2] = 32'h7FFF_FFFF;
        boundary_keys[3] = 32'h7FFF_FFFE;
        boundary_keys[4] = 32'h0000_0000;
        boundary_keys[5] = 32'hFFFF_FFFF;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = skt_pkg::CMD_INSERT;
        s_key = '0;
        s_record_ref = '0;
        src_idle_pct = 13;
        sink_idle_pct = 69;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        send_command(skt_pkg::CMD_LOCATE, 32'sd0, 32'h0000_0000);
        send_command(skt_pkg::CMD_INSERT, 32'sd0, 32'h0000_0000);
        send_command(skt_pkg::CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h5555_5555);
        send_command(skt_pkg::CMD_INSERT, 32'sd0, 32'h0000_0001);
        send_command(skt_pkg::CMD_INSERT, 32'sd0, 32'h0000_0002);
        send_command(skt_pkg::CMD_INSERT, -32'sd1, 32'hAAAA_AAAA);
        send_command(skt_pkg::CMD_INSERT, 32'sd1, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'sd0, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_LOCATE, 32'h8000_0000, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'h8000_0001, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'h7FFF_FFFE, 32'h0000_0000);
        send_command(skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_LOCATE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'sd2, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, -32'sd2, 32'h0000_0000);
        send_command(skt_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_command(skt_pkg::CMD_LOCATE, 32'h8000_0000, 32'h0000_0000);

        // The table fills during the first phase; later inserts all see a full table.
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 69 : 0;
            sink_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 13 : 0;
            for (n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(99) < 20) begin
                    send_command(skt_pkg::CMD_INSERT, pick_insert_key(), pick_record_ref());
                end else begin
                    send_command(skt_pkg::CMD_LOCATE, pick_locate_key(), pick_record_ref());
                end
            end
        end
        s_valid = 1'b0;

        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("sorted_key_table_insert_locate_unit regression: pass");
        end else begin
            $display("sorted_key_table_insert_locate_unit regression: fail");
        end
        $finish;
    end
endmodule

// File: sorted_key_table_insert_locate_unit.f
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/skt_encoder.sv
hdl/sorted_key_table_insert_locate_unit.sv
test/tb_top.sv
